@@ hw/rtl/mspi_pkg.sv @@
`timescale 1ns / 1ps

package mspi_pkg;

    // Request and card byte codes
    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_CARD  = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    // Final status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BLOCKLEN = 4'd1;
    localparam logic [3:0] ST_RESPONSE = 4'd2;
    localparam logic [3:0] ST_TOKEN    = 4'd3;
    localparam logic [3:0] ST_INIT     = 4'd4;
    localparam logic [3:0] ST_TIMEOUT  = 4'd5;
    localparam logic [3:0] ST_CRC      = 4'd6;
    localparam logic [3:0] ST_WRITE    = 4'd7;
    localparam logic [3:0] ST_OTHER    = 4'd8;

    // Card protocol bytes
    localparam logic [7:0] BYTE_DUMMY   = 8'hFF;
    localparam logic [7:0] BYTE_CMD_HDR = 8'h40;
    localparam logic [7:0] BYTE_CRC0    = 8'h95;
    localparam logic [7:0] BYTE_TOKEN   = 8'hFE;
    localparam logic [7:0] RESP_MASK    = 8'h1F;
    localparam logic [7:0] RESP_ACCEPT  = 8'h05;
    localparam logic [7:0] RESP_CRC_ERR = 8'h0B;
    localparam logic [7:0] RESP_WR_ERR  = 8'h0D;
    localparam logic [7:0] R1_READY     = 8'h00;
    localparam logic [7:0] R1_IDLE      = 8'h01;

    localparam logic [5:0] IDX_CMD0  = 6'd0;
    localparam logic [5:0] IDX_CMD1  = 6'd1;
    localparam logic [5:0] IDX_CMD13 = 6'd13;
    localparam logic [5:0] IDX_CMD16 = 6'd16;
    localparam logic [5:0] IDX_CMD17 = 6'd17;
    localparam logic [5:0] IDX_CMD24 = 6'd24;

    localparam int CNT_W = 14;
    localparam logic [2:0] FRAME_LEN = 3'd6;
    localparam logic [CNT_W-1:0] INIT_DUMMIES = 14'd11;
    localparam logic [CNT_W-1:0] CRC_BYTES    = 14'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] address;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
        logic [8:0]  buffer_index;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_active;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic [3:0] status;
        logic       fast_clock;
    } out_item_t;

    // One byte of a six byte command frame
    function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [31:0] arg,
                                              input logic [7:0] crc, input logic [2:0] fi);
        logic [7:0] b;
        case (fi)
            3'd0:    b = BYTE_CMD_HDR | {2'b00, idx};
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = crc;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/mspi_ram.sv @@
`timescale 1ns / 1ps

module mspi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mspi_seq.sv @@
`timescale 1ns / 1ps

module mspi_seq #(
    parameter int BLOCK_BYTES    = 512,
    parameter int RESPONSE_TRIES = 65,
    parameter int TOKEN_TRIES    = 1001,
    parameter int BUSY_TRIES     = 10001,
    localparam int AW            = $clog2(BLOCK_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mspi_pkg::in_item_t  item,
    input  logic [9:0]          blk_len,
    output mspi_pkg::out_item_t result,
    output logic                result_from_ram,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr
);

    typedef enum logic [27:0] {
        P_IDLE    = 28'b1 << 0,  P_I_DUMMY = 28'b1 << 1,  P_I_CMD0  = 28'b1 << 2,
        P_I_R0    = 28'b1 << 3,  P_I_GAP   = 28'b1 << 4,  P_I_CMD1  = 28'b1 << 5,
        P_I_R1    = 28'b1 << 6,  P_I_END   = 28'b1 << 7,  P_B_CMD16 = 28'b1 << 8,
        P_B_R16   = 28'b1 << 9,  P_B_GAP16 = 28'b1 << 10, P_X_CMD   = 28'b1 << 11,
        P_R_R1    = 28'b1 << 12, P_R_TOK   = 28'b1 << 13, P_R_DATA  = 28'b1 << 14,
        P_R_CRC   = 28'b1 << 15, P_W_R1    = 28'b1 << 16, P_W_GAP   = 28'b1 << 17,
        P_W_TOKEN = 28'b1 << 18, P_W_DATA  = 28'b1 << 19, P_W_CRC   = 28'b1 << 20,
        P_W_RESP  = 28'b1 << 21, P_W_BUSY  = 28'b1 << 22, P_S_GAP   = 28'b1 << 23,
        P_S_CMD   = 28'b1 << 24, P_S_HI    = 28'b1 << 25, P_S_LO    = 28'b1 << 26,
        P_T_END   = 28'b1 << 27
    } phase_t;

    localparam int CW = mspi_pkg::CNT_W;
    localparam logic [CW-1:0] RESP_MAX  = CW'(RESPONSE_TRIES);
    localparam logic [CW-1:0] TOKEN_MAX = CW'(TOKEN_TRIES);
    localparam logic [CW-1:0] BUSY_MAX  = CW'(BUSY_TRIES);
    localparam logic [CW-1:0] BLK_MAX   = CW'(BLOCK_BYTES);

    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  bc_reg, bc_next;
    logic [CW-1:0]  rc_reg, rc_next;
    logic [2:0]     fi_reg, fi_next;
    logic [3:0]     hs_reg, hs_next;
    logic [7:0]     lr_reg, lr_next;
    logic           isw_reg, isw_next;
    logic           cf_reg, cf_next;
    logic [31:0]    addr_reg, addr_next;
    logic [9:0]     len_reg, len_next;
    logic [CW-1:0]  xl_reg, xl_next;

    logic [CW-1:0]  bc_inc, rc_inc;
    logic [2:0]     fi_inc;
    logic [7:0]     rx;
    logic           r1_hit;
    logic           do_emit;
    logic [31:0]    idx_wide;
    logic [CW-1:0]  len_wide;

    assign rx       = item.rx_byte;
    assign bc_inc   = bc_reg + 1'b1;
    assign rc_inc   = rc_reg + 1'b1;
    assign fi_inc   = fi_reg + 1'b1;
    assign r1_hit   = (rx == mspi_pkg::R1_READY) || (rx == mspi_pkg::R1_IDLE)
                      || (rc_inc >= RESP_MAX);
    assign idx_wide = 32'(item.buffer_index);
    assign len_wide = CW'(blk_len);

    // Next state and result for one item
    always_comb
    begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        rc_next    = rc_reg;
        fi_next    = fi_reg;
        hs_next    = hs_reg;
        lr_next    = lr_reg;
        isw_next   = isw_reg;
        cf_next    = cf_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        xl_next    = xl_reg;
        do_emit    = 1'b0;
        result     = '0;
        wr_en      = 1'b0;

        if (item.command == mspi_pkg::CMD_LOAD)
        begin
            wr_en = accept && (idx_wide < 32'(BLOCK_BYTES));
        end
        else if (phase_reg == P_IDLE)
        begin
            if (item.command <= mspi_pkg::CMD_WRITE)
            begin
                hs_next = mspi_pkg::ST_OK;
                bc_next = '0;
                rc_next = '0;
                fi_next = '0;
                do_emit = 1'b1;
                if (item.command == mspi_pkg::CMD_INIT)
                begin
                    cf_next    = 1'b0;
                    phase_next = P_I_DUMMY;
                end
                else
                begin
                    isw_next   = (item.command == mspi_pkg::CMD_WRITE);
                    addr_next  = item.address;
                    len_next   = blk_len;
                    xl_next    = (len_wide > BLK_MAX) ? BLK_MAX : len_wide;
                    phase_next = P_B_CMD16;
                end
            end
        end
        else if (item.command == mspi_pkg::CMD_CARD)
        begin
            // advance on the received byte; a phase change clears retry and frame
            case (phase_reg)
                P_I_DUMMY:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= mspi_pkg::INIT_DUMMIES)
                    begin
                        phase_next = P_I_CMD0;
                    end
                end
                P_I_CMD0, P_I_CMD1, P_B_CMD16, P_X_CMD, P_S_CMD:
                begin
                    fi_next = fi_inc;
                    if (fi_inc >= mspi_pkg::FRAME_LEN)
                    begin
                        case (phase_reg)
                            P_I_CMD0:  phase_next = P_I_R0;
                            P_I_CMD1:  phase_next = P_I_R1;
                            P_B_CMD16: phase_next = P_B_R16;
                            P_X_CMD:   phase_next = isw_reg ? P_W_R1 : P_R_R1;
                            default:   phase_next = P_S_HI;
                        endcase
                    end
                end
                P_I_R0:
                begin
                    rc_next = rc_inc;
                    lr_next = rx;
                    if (r1_hit)
                    begin
                        if (rx == mspi_pkg::R1_IDLE)
                        begin
                            bc_next    = '0;
                            phase_next = P_I_GAP;
                        end
                        else
                        begin
                            hs_next    = mspi_pkg::ST_INIT;
                            phase_next = P_IDLE;
                        end
                    end
                end
                P_I_GAP: phase_next = P_I_CMD1;
                P_I_R1:
                begin
                    rc_next = rc_inc;
                    lr_next = rx;
                    if (r1_hit)
                    begin
                        bc_next = bc_inc;
                        if (rx == mspi_pkg::R1_IDLE && bc_inc < TOKEN_MAX)
                        begin
                            phase_next = P_I_GAP;
                        end
                        else
                        begin
                            phase_next = P_I_END;
                        end
                    end
                end
                P_I_END:
                begin
                    cf_next = 1'b1;
                    if (lr_reg == mspi_pkg::R1_READY)
                    begin
                        hs_next = mspi_pkg::ST_OK;
                    end
                    else if (lr_reg == mspi_pkg::R1_IDLE)
                    begin
                        hs_next = mspi_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        hs_next = mspi_pkg::ST_OTHER;
                    end
                    phase_next = P_IDLE;
                end
                P_B_R16:
                begin
                    rc_next = rc_inc;
                    lr_next = rx;
                    if (r1_hit)
                    begin
                        phase_next = P_B_GAP16;
                    end
                end
                P_B_GAP16:
                begin
                    if (lr_reg == mspi_pkg::R1_READY)
                    begin
                        phase_next = P_X_CMD;
                    end
                    else
                    begin
                        hs_next    = mspi_pkg::ST_BLOCKLEN;
                        phase_next = P_T_END;
                    end
                end
                P_R_R1:
                begin
                    rc_next = rc_inc;
                    lr_next = rx;
                    if (r1_hit)
                    begin
                        if (rx == mspi_pkg::R1_READY)
                        begin
                            phase_next = P_R_TOK;
                        end
                        else
                        begin
                            hs_next    = mspi_pkg::ST_RESPONSE;
                            phase_next = P_T_END;
                        end
                    end
                end
                P_R_TOK:
                begin
                    rc_next = rc_inc;
                    if (rx == mspi_pkg::BYTE_TOKEN)
                    begin
                        bc_next    = '0;
                        phase_next = (xl_reg != '0) ? P_R_DATA : P_R_CRC;
                    end
                    else if (rc_inc >= TOKEN_MAX)
                    begin
                        hs_next    = mspi_pkg::ST_TOKEN;
                        phase_next = P_T_END;
                    end
                end
                P_R_DATA:
                begin
                    result.read_valid = 1'b1;
                    result.read_byte  = rx;
                    bc_next           = bc_inc;
                    if (bc_inc >= xl_reg)
                    begin
                        result.read_last = 1'b1;
                        bc_next          = '0;
                        phase_next       = P_R_CRC;
                    end
                end
                P_R_CRC:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= mspi_pkg::CRC_BYTES)
                    begin
                        hs_next    = mspi_pkg::ST_OK;
                        phase_next = P_T_END;
                    end
                end
                P_W_R1:
                begin
                    rc_next = rc_inc;
                    if (rx == mspi_pkg::R1_READY)
                    begin
                        phase_next = P_W_GAP;
                    end
                    else if (rc_inc >= TOKEN_MAX)
                    begin
                        hs_next    = mspi_pkg::ST_RESPONSE;
                        phase_next = P_T_END;
                    end
                end
                P_W_GAP: phase_next = P_W_TOKEN;
                P_W_TOKEN:
                begin
                    bc_next    = '0;
                    phase_next = (xl_reg != '0) ? P_W_DATA : P_W_CRC;
                end
                P_W_DATA:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= xl_reg)
                    begin
                        bc_next    = '0;
                        phase_next = P_W_CRC;
                    end
                end
                P_W_CRC:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= mspi_pkg::CRC_BYTES)
                    begin
                        phase_next = P_W_RESP;
                    end
                end
                P_W_RESP:
                begin
                    rc_next = rc_inc;
                    if ((rx & mspi_pkg::RESP_MASK) == mspi_pkg::RESP_ACCEPT)
                    begin
                        hs_next    = mspi_pkg::ST_OK;
                        phase_next = P_W_BUSY;
                    end
                    else if ((rx & mspi_pkg::RESP_MASK) == mspi_pkg::RESP_CRC_ERR)
                    begin
                        hs_next    = mspi_pkg::ST_CRC;
                        phase_next = P_T_END;
                    end
                    else if ((rx & mspi_pkg::RESP_MASK) == mspi_pkg::RESP_WR_ERR)
                    begin
                        hs_next    = mspi_pkg::ST_WRITE;
                        phase_next = P_T_END;
                    end
                    else if (rc_inc >= RESP_MAX)
                    begin
                        hs_next    = mspi_pkg::ST_OTHER;
                        phase_next = P_W_BUSY;
                    end
                end
                P_W_BUSY:
                begin
                    rc_next = rc_inc;
                    if (rx != 8'h00)
                    begin
                        phase_next = (hs_reg == mspi_pkg::ST_OK) ? P_S_GAP : P_T_END;
                    end
                    else if (rc_inc >= BUSY_MAX)
                    begin
                        hs_next    = mspi_pkg::ST_TIMEOUT;
                        phase_next = P_T_END;
                    end
                end
                P_S_GAP: phase_next = P_S_CMD;
                P_S_HI:
                begin
                    rc_next = rc_inc;
                    lr_next = rx;
                    if (rx != mspi_pkg::BYTE_DUMMY || rc_inc >= RESP_MAX)
                    begin
                        phase_next = P_S_LO;
                    end
                end
                P_S_LO:
                begin
                    if (lr_reg != 8'h00 || rx != 8'h00)
                    begin
                        hs_next = mspi_pkg::ST_WRITE;
                    end
                    phase_next = P_T_END;
                end
                default: phase_next = P_IDLE;
            endcase

            if (phase_next != phase_reg)
            begin
                rc_next = '0;
                fi_next = '0;
            end

            if (phase_next == P_IDLE)
            begin
                result.done_res = 1'b1;
                result.status   = hs_next;
            end
            else
            begin
                do_emit = 1'b1;
            end
        end

        // Transmit byte for the phase entered
        if (do_emit)
        begin
            result.tx_valid      = 1'b1;
            result.tx_byte       = mspi_pkg::BYTE_DUMMY;
            result.select_active = 1'b1;
            case (phase_next)
                P_I_DUMMY, P_I_GAP, P_I_END, P_B_GAP16, P_S_GAP, P_T_END:
                    result.select_active = 1'b0;
                P_I_CMD0:
                    result.tx_byte = mspi_pkg::frame_byte(mspi_pkg::IDX_CMD0, 32'h0,
                                         mspi_pkg::BYTE_CRC0, fi_next);
                P_I_CMD1:
                    result.tx_byte = mspi_pkg::frame_byte(mspi_pkg::IDX_CMD1, 32'h0,
                                         mspi_pkg::BYTE_DUMMY, fi_next);
                P_B_CMD16:
                    result.tx_byte = mspi_pkg::frame_byte(mspi_pkg::IDX_CMD16,
                                         32'(len_next), mspi_pkg::BYTE_DUMMY, fi_next);
                P_X_CMD:
                    result.tx_byte = mspi_pkg::frame_byte(
                                         isw_next ? mspi_pkg::IDX_CMD24 : mspi_pkg::IDX_CMD17,
                                         addr_next, mspi_pkg::BYTE_DUMMY, fi_next);
                P_S_CMD:
                    result.tx_byte = mspi_pkg::frame_byte(mspi_pkg::IDX_CMD13, 32'h0,
                                         mspi_pkg::BYTE_DUMMY, fi_next);
                P_W_TOKEN:
                    result.tx_byte = mspi_pkg::BYTE_TOKEN;
                default:
                    result.select_active = 1'b1;
            endcase
        end
        result.fast_clock = cf_next;
    end

    // Write data comes from the buffer through its registered read port, beside the result register
    assign result_from_ram = do_emit && (phase_next == P_W_DATA);
    assign rd_en           = accept && result_from_ram;
    assign rd_addr         = bc_next[AW-1:0];
    assign wr_addr         = idx_wide[AW-1:0];
    assign wr_data         = item.write_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            bc_reg    <= '0;
            rc_reg    <= '0;
            fi_reg    <= '0;
            hs_reg    <= '0;
            lr_reg    <= mspi_pkg::BYTE_DUMMY;
            isw_reg   <= 1'b0;
            cf_reg    <= 1'b0;
            addr_reg  <= '0;
            len_reg   <= '0;
            xl_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            rc_reg    <= rc_next;
            fi_reg    <= fi_next;
            hs_reg    <= hs_next;
            lr_reg    <= lr_next;
            isw_reg   <= isw_next;
            cf_reg    <= cf_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            xl_reg    <= xl_next;
        end
    end

    a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.done_res |-> !result.tx_valid)
        else $error("done result carries a transmit byte");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.read_last |-> result.read_valid)
        else $error("read_last without read data");

    a_data_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == P_W_DATA || phase_reg == P_R_DATA) |-> bc_reg < xl_reg)
        else $error("data byte count beyond block length");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fi_reg < mspi_pkg::FRAME_LEN)
        else $error("frame index out of range");

endmodule

@@ hw/rtl/mmc_spi_host_transaction_engine.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Carries
// in       in   in_valid/in_stall    request, card byte or write buffer load
// out      out  out_valid/out_stall  tx byte + select, read data, done + status
// cfg      in   cfg_valid/cfg_ready  block length in bytes
//
// One item per cycle while in_stall is low; each accepted item gives one result in the next cycle.
// The sequencer decides the next byte combinationally; write data comes
// from the buffer RAM through its registered read port beside the result register.
// in_stall is raised only while a result waits and out_stall is high.
// Reset: sequencer idle, fast_clock low; the write buffer is not cleared.
module mmc_spi_host_transaction_engine #(
    parameter int BLOCK_BYTES    = 512,
    parameter int RESPONSE_TRIES = 65,
    parameter int TOKEN_TRIES    = 1001,
    parameter int BUSY_TRIES     = 10001
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mspi_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mspi_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [9:0]          cfg_data
);

    localparam int AW = $clog2(BLOCK_BYTES);

    logic                in_accept;
    logic [9:0]          blen_reg;
    mspi_pkg::out_item_t result;
    logic                result_from_ram;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [7:0]          wr_data, rd_data;
    mspi_pkg::out_item_t out_reg;
    logic                from_ram_reg;
    logic                out_valid_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg <= 10'd512;
        end
        else if (cfg_valid)
        begin
            blen_reg <= cfg_data;
        end
    end

    mspi_seq #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .RESPONSE_TRIES (RESPONSE_TRIES),
        .TOKEN_TRIES    (TOKEN_TRIES),
        .BUSY_TRIES     (BUSY_TRIES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .item            (in_data),
        .blk_len         (blen_reg),
        .result          (result),
        .result_from_ram (result_from_ram),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr)
    );

    mspi_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg      <= result;
            from_ram_reg <= result_from_ram;
        end
    end

    always_comb
    begin
        out_data = out_reg;
        if (from_ram_reg)
        begin
            out_data.tx_byte = rd_data;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ tb/mmc_spi_host_transaction_engine_test.sv @@
`timescale 1ns / 1ps

module mmc_spi_host_transaction_engine_test;

    localparam int BLK_MAX     = 512;
    localparam int R1_LIMIT    = 65;
    localparam int TOK_LIMIT   = 1001;
    localparam int BUSY_LIMIT  = 10001;
    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 650;

    typedef enum logic [5:0] {
        PH_IDLE, PH_I_DUMMY, PH_I_CMD0, PH_I_R0, PH_I_GAP, PH_I_CMD1, PH_I_R1, PH_I_END,
        PH_B_CMD16, PH_B_R16, PH_B_GAP16, PH_X_CMD,
        PH_R_R1, PH_R_TOK, PH_R_DATA, PH_R_CRC,
        PH_W_R1, PH_W_GAP, PH_W_TOKEN, PH_W_DATA, PH_W_CRC, PH_W_RESP, PH_W_BUSY,
        PH_S_GAP, PH_S_CMD, PH_S_HI, PH_S_LO, PH_T_END, PH_NONE
    } seq_phase_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    mspi_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    mspi_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [9:0]          cfg_data;

    mmc_spi_host_transaction_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Sequencer shadow state
    seq_phase_t  seq;
    int          bcnt;
    int          rcnt;
    int          fidx;
    logic [3:0]  hold_st;
    logic [7:0]  last_r1;
    bit          wr_op;
    bit          fast;
    logic [7:0]  wbuf [BLK_MAX];
    bit          loaded [BLK_MAX];
    logic [9:0]  blen;
    logic [31:0] lat_addr;
    logic [9:0]  lat_len;
    int          xlen;

    // Scoreboard and handshake bookkeeping
    mspi_pkg::out_item_t pending_results [$];
    mspi_pkg::in_item_t  pending_items [$];
    int          n_sent;
    int          n_taken;
    int          n_errors;
    int          idle_cycles;
    bit          in_taken;
    bit          out_taken;
    int          in_gap;
    int          out_hold;
    bit          calm;
    seq_phase_t  mute_ph;

    function automatic int wait_draw();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function void goto_ph(input seq_phase_t p);
        seq  = p;
        rcnt = 0;
        fidx = 0;
    endfunction

    function bit r1_seen(input logic [7:0] rx);
        rcnt++;
        last_r1 = rx;
        return rx == mspi_pkg::R1_READY || rx == mspi_pkg::R1_IDLE || rcnt >= R1_LIMIT;
    endfunction

    function logic [7:0] cmd_frame(input logic [5:0] idx, input logic [31:0] arg,
                                   input logic [7:0] crc);
        case (fidx)
            0:       return mspi_pkg::BYTE_CMD_HDR | {2'b00, idx};
            1:       return arg[31:24];
            2:       return arg[23:16];
            3:       return arg[15:8];
            4:       return arg[7:0];
            default: return crc;
        endcase
    endfunction

    // Next byte to exchange and its select level
    function void offer(inout mspi_pkg::out_item_t o);
        o.tx_valid      = 1'b1;
        o.tx_byte       = mspi_pkg::BYTE_DUMMY;
        o.select_active = 1'b1;
        case (seq)
            PH_I_DUMMY, PH_I_GAP, PH_I_END, PH_B_GAP16, PH_S_GAP, PH_T_END:
                o.select_active = 1'b0;
            PH_I_CMD0:
                o.tx_byte = cmd_frame(mspi_pkg::IDX_CMD0, 32'd0, mspi_pkg::BYTE_CRC0);
            PH_I_CMD1:
                o.tx_byte = cmd_frame(mspi_pkg::IDX_CMD1, 32'd0, mspi_pkg::BYTE_DUMMY);
            PH_B_CMD16:
                o.tx_byte = cmd_frame(mspi_pkg::IDX_CMD16, {22'd0, lat_len},
                                      mspi_pkg::BYTE_DUMMY);
            PH_X_CMD:
                o.tx_byte = cmd_frame(wr_op ? mspi_pkg::IDX_CMD24 : mspi_pkg::IDX_CMD17,
                                      lat_addr, mspi_pkg::BYTE_DUMMY);
            PH_S_CMD:
                o.tx_byte = cmd_frame(mspi_pkg::IDX_CMD13, 32'd0, mspi_pkg::BYTE_DUMMY);
            PH_W_TOKEN: o.tx_byte = mspi_pkg::BYTE_TOKEN;
            PH_W_DATA:  o.tx_byte = bcnt < BLK_MAX ? wbuf[bcnt] : mspi_pkg::BYTE_DUMMY;
            default: ;
        endcase
    endfunction

    function void frame_step();
        fidx++;
        if (fidx >= 6)
        begin
            case (seq)
                PH_I_CMD0:  goto_ph(PH_I_R0);
                PH_I_CMD1:  goto_ph(PH_I_R1);
                PH_B_CMD16: goto_ph(PH_B_R16);
                PH_X_CMD:   goto_ph(wr_op ? PH_W_R1 : PH_R_R1);
                default:    goto_ph(PH_S_HI);
            endcase
        end
    endfunction

    function void abort_with(input logic [3:0] st);
        hold_st = st;
        goto_ph(PH_T_END);
    endfunction

    // Consume the card byte for the last offered byte
    function void card_step(input logic [7:0] rx, inout mspi_pkg::out_item_t o);
        logic [7:0] m;
        case (seq)
            PH_I_DUMMY:
            begin
                bcnt++;
                if (bcnt >= 11) goto_ph(PH_I_CMD0);
            end
            PH_I_CMD0, PH_I_CMD1, PH_B_CMD16, PH_X_CMD, PH_S_CMD: frame_step();
            PH_I_R0:
                if (r1_seen(rx))
                begin
                    if (last_r1 == mspi_pkg::R1_IDLE)
                    begin
                        bcnt = 0;
                        goto_ph(PH_I_GAP);
                    end
                    else
                    begin
                        hold_st = mspi_pkg::ST_INIT;
                        goto_ph(PH_IDLE);
                    end
                end
            PH_I_GAP: goto_ph(PH_I_CMD1);
            PH_I_R1:
                if (r1_seen(rx))
                begin
                    bcnt++;
                    if (last_r1 == mspi_pkg::R1_IDLE && bcnt < TOK_LIMIT) goto_ph(PH_I_GAP);
                    else goto_ph(PH_I_END);
                end
            PH_I_END:
            begin
                fast = 1'b1;
                hold_st = last_r1 == mspi_pkg::R1_READY ? mspi_pkg::ST_OK :
                          (last_r1 == mspi_pkg::R1_IDLE ? mspi_pkg::ST_TIMEOUT
                                                        : mspi_pkg::ST_OTHER);
                goto_ph(PH_IDLE);
            end
            PH_B_R16:
                if (r1_seen(rx)) goto_ph(PH_B_GAP16);
            PH_B_GAP16:
                if (last_r1 == mspi_pkg::R1_READY) goto_ph(PH_X_CMD);
                else abort_with(mspi_pkg::ST_BLOCKLEN);
            PH_R_R1:
                if (r1_seen(rx))
                begin
                    if (last_r1 == mspi_pkg::R1_READY) goto_ph(PH_R_TOK);
                    else abort_with(mspi_pkg::ST_RESPONSE);
                end
            PH_R_TOK:
            begin
                rcnt++;
                if (rx == mspi_pkg::BYTE_TOKEN)
                begin
                    bcnt = 0;
                    goto_ph(xlen != 0 ? PH_R_DATA : PH_R_CRC);
                end
                else if (rcnt >= TOK_LIMIT) abort_with(mspi_pkg::ST_TOKEN);
            end
            PH_R_DATA:
            begin
                o.read_valid = 1'b1;
                o.read_byte  = rx;
                bcnt++;
                if (bcnt >= xlen)
                begin
                    o.read_last = 1'b1;
                    bcnt = 0;
                    goto_ph(PH_R_CRC);
                end
            end
            PH_R_CRC:
            begin
                bcnt++;
                if (bcnt >= 2) abort_with(mspi_pkg::ST_OK);
            end
            PH_W_R1:
            begin
                rcnt++;
                if (rx == mspi_pkg::R1_READY) goto_ph(PH_W_GAP);
                else if (rcnt >= TOK_LIMIT) abort_with(mspi_pkg::ST_RESPONSE);
            end
            PH_W_GAP: goto_ph(PH_W_TOKEN);
            PH_W_TOKEN:
            begin
                bcnt = 0;
                goto_ph(xlen != 0 ? PH_W_DATA : PH_W_CRC);
            end
            PH_W_DATA:
            begin
                bcnt++;
                if (bcnt >= xlen)
                begin
                    bcnt = 0;
                    goto_ph(PH_W_CRC);
                end
            end
            PH_W_CRC:
            begin
                bcnt++;
                if (bcnt >= 2) goto_ph(PH_W_RESP);
            end
            PH_W_RESP:
            begin
                rcnt++;
                m = rx & mspi_pkg::RESP_MASK;
                if (m == mspi_pkg::RESP_ACCEPT)
                begin
                    hold_st = mspi_pkg::ST_OK;
                    goto_ph(PH_W_BUSY);
                end
                else if (m == mspi_pkg::RESP_CRC_ERR) abort_with(mspi_pkg::ST_CRC);
                else if (m == mspi_pkg::RESP_WR_ERR) abort_with(mspi_pkg::ST_WRITE);
                else if (rcnt >= R1_LIMIT)
                begin
                    hold_st = mspi_pkg::ST_OTHER;
                    goto_ph(PH_W_BUSY);
                end
            end
            PH_W_BUSY:
            begin
                rcnt++;
                if (rx != 8'h00) goto_ph(hold_st == mspi_pkg::ST_OK ? PH_S_GAP : PH_T_END);
                else if (rcnt >= BUSY_LIMIT) abort_with(mspi_pkg::ST_TIMEOUT);
            end
            PH_S_GAP: goto_ph(PH_S_CMD);
            PH_S_HI:
            begin
                rcnt++;
                last_r1 = rx;
                if (rx != mspi_pkg::BYTE_DUMMY || rcnt >= R1_LIMIT) goto_ph(PH_S_LO);
            end
            PH_S_LO:
            begin
                if (last_r1 != 8'h00 || rx != 8'h00) hold_st = mspi_pkg::ST_WRITE;
                goto_ph(PH_T_END);
            end
            default: goto_ph(PH_IDLE);
        endcase
    endfunction

    // Expected result for one accepted item
    function mspi_pkg::out_item_t predict_result(input mspi_pkg::in_item_t it);
        mspi_pkg::out_item_t o;
        o = '0;
        if (it.command == mspi_pkg::CMD_LOAD)
        begin
            wbuf[it.buffer_index]   = it.write_byte;
            loaded[it.buffer_index] = 1'b1;
        end
        else if (seq == PH_IDLE)
        begin
            if (it.command <= mspi_pkg::CMD_WRITE)
            begin
                hold_st = mspi_pkg::ST_OK;
                bcnt    = 0;
                if (it.command == mspi_pkg::CMD_INIT)
                begin
                    fast = 1'b0;
                    goto_ph(PH_I_DUMMY);
                end
                else
                begin
                    wr_op    = it.command == mspi_pkg::CMD_WRITE;
                    lat_addr = it.address;
                    lat_len  = blen;
                    xlen     = blen > BLK_MAX ? BLK_MAX : blen;
                    goto_ph(PH_B_CMD16);
                end
                offer(o);
            end
        end
        else if (it.command == mspi_pkg::CMD_CARD)
        begin
            card_step(it.rx_byte, o);
            if (seq == PH_IDLE)
            begin
                o.done_res = 1'b1;
                o.status   = hold_st;
            end
            else
            begin
                offer(o);
            end
        end
        o.fast_clock = fast;
        return o;
    endfunction

    // Driver: one item from the pending queue, with a random gap after each
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap = wait_draw();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            out_hold  = wait_draw();
        end
        if (out_hold > 0 && rst_n)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: check results, then predict for the item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && !out_stall)
            begin
                out_taken   = 1'b1;
                idle_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result %p", out_data);
                end
                else
                begin
                    mspi_pkg::out_item_t e;
                    e = pending_results.pop_front();
                    if (out_data.tx_valid !== e.tx_valid || out_data.tx_byte !== e.tx_byte ||
                        out_data.select_active !== e.select_active ||
                        out_data.read_valid !== e.read_valid ||
                        out_data.read_byte !== e.read_byte ||
                        out_data.read_last !== e.read_last ||
                        out_data.done_res !== e.done_res || out_data.status !== e.status ||
                        out_data.fast_clock !== e.fast_clock)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected %p got %p", e, out_data);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken    = 1'b1;
                idle_cycles = 0;
                pending_results.push_back(predict_result(in_data));
                n_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                blen        = cfg_data;
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Card answer for the current phase; a muted phase never gets what it waits for
    function automatic logic [7:0] card_reply();
        int r;
        r = $urandom_range(0, 9);
        if (seq == mute_ph)
            return seq == PH_W_BUSY ? 8'h00 :
                   (seq == PH_I_R1 ? mspi_pkg::R1_IDLE : mspi_pkg::BYTE_DUMMY);
        case (seq)
            PH_I_R0:  return r < 7 ? mspi_pkg::R1_IDLE :
                             (r == 7 ? mspi_pkg::BYTE_DUMMY : 8'($urandom));
            PH_I_R1:  return r < 3 ? mspi_pkg::BYTE_DUMMY : (r < 6 ? mspi_pkg::R1_IDLE :
                             (r == 9 ? 8'($urandom) : mspi_pkg::R1_READY));
            PH_B_R16, PH_R_R1, PH_W_R1:
                      return r < 3 ? mspi_pkg::BYTE_DUMMY :
                             (r == 9 ? 8'($urandom_range(1, 255)) : mspi_pkg::R1_READY);
            PH_R_TOK: return r < 3 ? mspi_pkg::BYTE_DUMMY :
                             (r == 9 ? 8'($urandom) : mspi_pkg::BYTE_TOKEN);
            PH_W_RESP:
                if (r < 6) return {3'($urandom), 5'h05};
                else if (r == 6) return {3'($urandom), 5'h0B};
                else if (r == 7) return {3'($urandom), 5'h0D};
                else return r == 8 ? mspi_pkg::BYTE_DUMMY : 8'($urandom);
            PH_W_BUSY: return r < 5 ? 8'h00 : 8'($urandom_range(1, 255));
            PH_S_HI:  return r < 3 ? mspi_pkg::BYTE_DUMMY : (r == 9 ? 8'($urandom) : 8'h00);
            PH_S_LO:  return r == 9 ? 8'($urandom) : 8'h00;
            default:  return 8'($urandom);
        endcase
    endfunction

    task automatic send(input logic [2:0] cmd, input logic [31:0] addr,
                        input logic [7:0] rx, input logic [7:0] wb, input logic [8:0] idx);
        mspi_pkg::in_item_t it;
        it.command      = cmd;
        it.address      = addr;
        it.rx_byte      = rx;
        it.write_byte   = wb;
        it.buffer_index = idx;
        pending_items.push_back(it);
        n_sent++;
        if (n_sent % 40 == 0) calm = $urandom_range(0, 3) == 0;
        while (n_taken != n_sent) @(negedge clk);
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: send(mspi_pkg::CMD_LOAD, $urandom, 8'($urandom), 8'($urandom), 9'($urandom));
            1: send(3'($urandom_range(0, 2)), $urandom, 8'($urandom), 8'($urandom),
                    9'($urandom));
            default: send(3'($urandom_range(5, 7)), $urandom, 8'($urandom), 8'($urandom),
                          9'($urandom));
        endcase
    endtask

    // One whole transaction, with the card answering each byte
    task automatic run_txn(input logic [2:0] cmd, input logic [31:0] addr,
                           input seq_phase_t mute);
        int n;
        if (cmd == mspi_pkg::CMD_WRITE)
        begin
            n = blen > BLK_MAX ? BLK_MAX : blen;
            for (int i = 0; i < n; i++)
                if (!loaded[i])
                    send(mspi_pkg::CMD_LOAD, $urandom, 8'($urandom), 8'($urandom), 9'(i));
        end
        mute_ph = mute;
        send(cmd, addr, 8'($urandom), 8'($urandom), 9'($urandom));
        while (seq != PH_IDLE)
        begin
            if ($urandom_range(0, 19) == 0) noise_item();
            else send(mspi_pkg::CMD_CARD, $urandom, card_reply(), 8'($urandom),
                      9'($urandom));
        end
        mute_ph = PH_NONE;
    endtask

    task automatic set_length(input logic [9:0] v);
        while (n_taken != n_sent || pending_results.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [9:0] v;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        in_gap    = 0;
        out_hold  = 0;
        calm      = 1'b0;
        mute_ph   = PH_NONE;
        n_sent    = 0;
        n_taken   = 0;
        n_errors  = 0;
        idle_cycles = 0;
        seq       = PH_IDLE;
        rcnt      = 0;
        fidx      = 0;
        bcnt      = 0;
        hold_st   = mspi_pkg::ST_OK;
        last_r1   = mspi_pkg::BYTE_DUMMY;
        wr_op     = 1'b0;
        fast      = 1'b0;
        blen      = 10'd512;
        lat_addr  = '0;
        lat_len   = '0;
        xlen      = 0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored items while idle, init outcomes, lengths and failures
        send(mspi_pkg::CMD_CARD, 32'd0, 8'h00, 8'd0, 9'd0);
        send(3'd5, 32'd0, 8'd0, 8'd0, 9'd0);
        send(3'd6, 32'd0, 8'd0, 8'd0, 9'd0);
        send(3'd7, '1, '1, '1, '1);
        send(mspi_pkg::CMD_LOAD, 32'd0, 8'd0, 8'hFF, 9'd511);
        send(mspi_pkg::CMD_LOAD, 32'd0, 8'd0, 8'h00, 9'd0);
        run_txn(mspi_pkg::CMD_INIT, 32'd0, PH_I_R0);
        run_txn(mspi_pkg::CMD_INIT, 32'd0, PH_NONE);
        set_length(10'd1);
        run_txn(mspi_pkg::CMD_READ, 32'd0, PH_NONE);
        run_txn(mspi_pkg::CMD_WRITE, 32'hFFFF_FFFF, PH_NONE);
        set_length(10'd0);
        run_txn(mspi_pkg::CMD_READ, 32'hFFFF_FFFF, PH_NONE);
        run_txn(mspi_pkg::CMD_WRITE, 32'd0, PH_NONE);
        set_length(10'd1023);
        run_txn(mspi_pkg::CMD_READ, 32'hA5A5_5A5A, PH_B_R16);
        set_length(10'd3);
        run_txn(mspi_pkg::CMD_WRITE, $urandom, PH_W_RESP);
        run_txn(mspi_pkg::CMD_WRITE, $urandom, PH_S_HI);

        // Random transactions up to the item target
        while (n_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       v = 10'd0;
                    1:       v = 10'($urandom_range(13, 24));
                    default: v = 10'($urandom_range(1, 12));
                endcase
                set_length(v);
            end
            case ($urandom_range(0, 11))
                0, 1:    run_txn(mspi_pkg::CMD_INIT, $urandom, PH_NONE);
                2:       send(3'($urandom_range(3, 7)), $urandom, 8'($urandom), 8'($urandom),
                              9'($urandom));
                3:       run_txn(3'($urandom_range(1, 2)), $urandom,
                                 $urandom_range(0, 1) ? PH_B_R16 : PH_R_R1);
                4, 5, 6, 7: run_txn(mspi_pkg::CMD_READ, $urandom, PH_NONE);
                default: run_txn(mspi_pkg::CMD_WRITE, $urandom, PH_NONE);
            endcase
        end

        while (n_taken != n_sent || pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ mmc_spi_host_transaction_engine.f @@
hw/rtl/mspi_pkg.sv
hw/rtl/mspi_ram.sv
hw/rtl/mspi_seq.sv
hw/rtl/mmc_spi_host_transaction_engine.sv
tb/mmc_spi_host_transaction_engine_test.sv
